>>> design/fvc_pkg.sv
`default_nettype none
package fvc_pkg;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SPHERE = 2'd1;
    localparam logic [1:0] CMD_BOX_CE = 2'd2;
    localparam logic [1:0] CMD_BOX_MM = 2'd3;

    localparam logic [1:0] SET_BASE = 2'd0;
    localparam logic [1:0] SET_EXCL = 2'd1;
    localparam logic [1:0] SET_INCL = 2'd2;

    localparam logic REG_INC_COUNT = 1'b0;
    localparam logic REG_EXCL_EN   = 1'b1;

    localparam int NUM_FIXED = 6;
    localparam int PLANE_W   = 128;

    typedef struct packed {
        logic signed [31:0] d;
        logic signed [31:0] c;
        logic signed [31:0] b;
        logic signed [31:0] a;
    } t_plane;

endpackage
`default_nettype wire

>>> design/frustum_visibility_cull.sv
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------
// command  | start, busy                | i_cmd, i_plane_set, i_plane_index,
//          |                            | i_ax..i_aw, i_bx..i_bz
// result   | o_valid (one-cycle strobe) | o_visible
// config   | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// Plane write: busy stays low. Test: one shared 33x33 multiplier
// visits each plane in turn over 6 base, inclusion_count inclusion (capped
// at MAX_INCLUSION_PLANES) and, if exclusion is enabled, 6 exclusion planes,
// stopping at the first decisive plane (at most 28 planes).
// o_valid pulses in the first cycle that busy is low again.
// Synchronous active-low reset clears the plane valid bits (stores read zero)
// and the config and state registers. The result side cannot stall.
`default_nettype none
module frustum_visibility_cull #(
    parameter int MAX_INCLUSION_PLANES = 16,
    parameter int FRAC_BITS            = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  i_cmd,
    input  wire logic        [1:0]  i_plane_set,
    input  wire logic        [3:0]  i_plane_index,
    input  wire logic signed [31:0] i_ax,
    input  wire logic signed [31:0] i_ay,
    input  wire logic signed [31:0] i_az,
    input  wire logic signed [31:0] i_aw,
    input  wire logic signed [31:0] i_bx,
    input  wire logic signed [31:0] i_by,
    input  wire logic signed [31:0] i_bz,
    output logic                    o_valid,
    output logic                    o_visible,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [2:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);
    localparam int DEPTH = 2 * fvc_pkg::NUM_FIXED + MAX_INCLUSION_PLANES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (AW > 5) ? AW : 5;
    localparam int ACC_W = 72;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;

    localparam logic [1:0] PH_BASE = 2'd0;
    localparam logic [1:0] PH_INCL = 2'd1;
    localparam logic [1:0] PH_EXCL = 2'd2;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    logic [AW-1:0] r_idx, n_idx;
    logic [2:0]  r_step, n_step;
    logic        r_box, r_mm;
    logic signed [32:0] r_s [3];
    logic signed [32:0] r_t [3];
    logic signed [31:0] r_r;
    fvc_pkg::t_plane r_plane;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [65:0] r_prod;
    logic        r_pv, r_psub;
    logic        r_rd_vld;
    logic [DEPTH-1:0] r_vld;
    logic [4:0]  r_inc_count, r_ninc;
    logic        r_excl_en;
    logic        r_valid, n_valid, r_visible, n_visible;

    logic        accept, wr_ok, cfg_wr;
    logic [AW-1:0] waddr, raddr;
    logic [fvc_pkg::PLANE_W-1:0] ram_q;
    fvc_pkg::t_plane rd_plane;
    logic signed [32:0] op_a, op_b, a_sel, s_sel, t_sel;
    logic signed [ACC_W-1:0] k_d, k_r, k_val;
    logic        acc_neg, acc_pos;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign o_valid   = r_valid;
    assign o_visible = r_visible;
    assign prdata = (paddr[2] == fvc_pkg::REG_EXCL_EN) ? {31'd0, r_excl_en}
                                                       : {27'd0, r_inc_count};

    always_comb begin
        wr_ok = 1'b0;
        waddr = AW'(i_plane_index);
        case (i_plane_set)
            fvc_pkg::SET_BASE: begin
                wr_ok = (int'(i_plane_index) < fvc_pkg::NUM_FIXED);
            end
            fvc_pkg::SET_EXCL: begin
                wr_ok = (int'(i_plane_index) < fvc_pkg::NUM_FIXED);
                waddr = AW'(i_plane_index) + AW'(fvc_pkg::NUM_FIXED);
            end
            fvc_pkg::SET_INCL: begin
                wr_ok = (int'(i_plane_index) < MAX_INCLUSION_PLANES);
                waddr = AW'(i_plane_index) + AW'(2 * fvc_pkg::NUM_FIXED);
            end
            default: wr_ok = 1'b0;
        endcase
        wr_ok = wr_ok && accept && (i_cmd == fvc_pkg::CMD_WRITE);
    end

    always_comb begin
        case (r_phase)
            PH_EXCL: raddr = r_idx + AW'(fvc_pkg::NUM_FIXED);
            PH_INCL: raddr = r_idx + AW'(2 * fvc_pkg::NUM_FIXED);
            default: raddr = r_idx;
        endcase
    end

    fvc_ram #(.WIDTH(fvc_pkg::PLANE_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (waddr),
        .i_wdata ({i_aw, i_az, i_ay, i_ax}),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign rd_plane = r_rd_vld ? fvc_pkg::t_plane'(ram_q) : '0;

    always_comb begin
        k_d = ACC_W'(rd_plane.d) <<< FRAC_BITS;
        if (r_mm) begin
            k_d = k_d <<< 1;
        end
        k_r = ACC_W'(r_r) <<< FRAC_BITS;
        if (r_box) begin
            k_val = k_d;
        end else if (r_phase == PH_EXCL) begin
            k_val = k_d - k_r;
        end else begin
            k_val = k_d + k_r;
        end
    end

    always_comb begin
        case (r_step) inside
            3'd0, 3'd3: begin
                a_sel = 33'(r_plane.a); s_sel = r_s[0]; t_sel = r_t[0];
            end
            3'd1, 3'd4: begin
                a_sel = 33'(r_plane.b); s_sel = r_s[1]; t_sel = r_t[1];
            end
            default: begin
                a_sel = 33'(r_plane.c); s_sel = r_s[2]; t_sel = r_t[2];
            end
        endcase
        if (r_step < 3'd3) begin
            op_a = a_sel;
            op_b = s_sel;
        end else begin
            op_a = a_sel[32] ? -a_sel : a_sel;
            op_b = t_sel;
        end
    end

    assign acc_neg = r_acc[ACC_W-1];
    assign acc_pos = !acc_neg && (r_acc != '0);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_step    = r_step;
        n_acc     = r_acc;
        n_valid   = 1'b0;
        n_visible = r_visible;
        if (r_pv) begin
            n_acc = r_psub ? r_acc - ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd != fvc_pkg::CMD_WRITE)) begin
                    n_state = S_RD;
                    n_phase = PH_BASE;
                    n_idx   = '0;
                end
            end
            S_RD: n_state = S_LOAD;
            S_LOAD: begin
                n_acc   = k_val;
                n_step  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_step = r_step + 3'd1;
                if (r_step == (r_box ? 3'd5 : 3'd2)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_EVAL;
            S_EVAL: begin
                n_state = S_RD;
                if (r_phase == PH_EXCL) begin
                    if (r_box ? acc_neg : !acc_pos) begin
                        n_state = S_IDLE; n_valid = 1'b1; n_visible = 1'b1;
                    end else if (int'(r_idx) == fvc_pkg::NUM_FIXED - 1) begin
                        n_state = S_IDLE; n_valid = 1'b1; n_visible = 1'b0;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end else if (acc_neg) begin
                    n_state = S_IDLE; n_valid = 1'b1; n_visible = 1'b0;
                end else if (r_phase == PH_BASE
                             && int'(r_idx) != fvc_pkg::NUM_FIXED - 1) begin
                    n_idx = r_idx + AW'(1);
                end else if (r_phase == PH_BASE && r_ninc != 5'd0) begin
                    n_phase = PH_INCL; n_idx = '0;
                end else if (r_phase == PH_INCL
                             && (CW'(r_idx) + CW'(1)) != CW'(r_ninc)) begin
                    n_idx = r_idx + AW'(1);
                end else if (r_excl_en) begin
                    n_phase = PH_EXCL; n_idx = '0;
                end else begin
                    n_state = S_IDLE; n_valid = 1'b1; n_visible = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_pv        <= 1'b0;
            r_vld       <= '0;
            r_inc_count <= '0;
            r_ninc      <= '0;
            r_excl_en   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pv    <= (r_state == S_MUL);
            if (wr_ok) begin
                r_vld[waddr] <= 1'b1;
            end
            if (cfg_wr) begin
                if (paddr[2] == fvc_pkg::REG_INC_COUNT) begin
                    r_inc_count <= pwdata[4:0];
                    r_ninc <= (int'(pwdata[4:0]) > MAX_INCLUSION_PLANES)
                              ? 5'(MAX_INCLUSION_PLANES) : pwdata[4:0];
                end else begin
                    r_excl_en <= pwdata[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase   <= n_phase;
        r_idx     <= n_idx;
        r_step    <= n_step;
        r_acc     <= n_acc;
        r_visible <= n_visible;
        r_rd_vld  <= r_vld[raddr];
        r_prod    <= op_a * op_b;
        r_psub    <= (r_step >= 3'd3) && (r_phase == PH_EXCL);
        if (r_state == S_LOAD) begin
            r_plane <= rd_plane;
        end
        if (accept) begin
            r_box <= (i_cmd != fvc_pkg::CMD_SPHERE);
            r_mm  <= (i_cmd == fvc_pkg::CMD_BOX_MM);
            r_r   <= i_aw;
            if (i_cmd == fvc_pkg::CMD_BOX_MM) begin
                r_s[0] <= 33'(i_ax) + 33'(i_bx);
                r_s[1] <= 33'(i_ay) + 33'(i_by);
                r_s[2] <= 33'(i_az) + 33'(i_bz);
                r_t[0] <= 33'(i_bx) - 33'(i_ax);
                r_t[1] <= 33'(i_by) - 33'(i_ay);
                r_t[2] <= 33'(i_bz) - 33'(i_az);
            end else begin
                r_s[0] <= 33'(i_ax);
                r_s[1] <= 33'(i_ay);
                r_s[2] <= 33'(i_az);
                r_t[0] <= 33'(i_bx);
                r_t[1] <= 33'(i_by);
                r_t[2] <= 33'(i_bz);
            end
        end
    end
endmodule
`default_nettype wire

>>> design/fvc_ram.sv
`default_nettype none
module fvc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 28
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> design/fvc_checker.sv
`default_nettype none
module fvc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_cmd,
    input wire logic       o_valid,
    input wire logic       pready
);
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without transaction");

    a_busy_end_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid) else $error("test ended without result");

    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == fvc_pkg::CMD_WRITE) |=> (!busy && !o_valid))
        else $error("plane write stalled or gave result");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd != fvc_pkg::CMD_WRITE) |=> busy)
        else $error("test transaction not started");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");
endmodule

bind frustum_visibility_cull fvc_checker u_fvc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_valid (o_valid),
    .pready  (pready)
);
`default_nettype wire

>>> dv/tb.sv
`default_nettype none
module tb;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [1:0]       set;
        logic [3:0]       idx;
        logic [6:0][31:0] f;   // ax ay az aw bx by bz, f[0] = ax
        bit               typed;
        bit               vis;
    } t_stim;

    logic i_clk, i_rst_n, start, busy;
    logic [1:0] i_cmd, i_plane_set;
    logic [3:0] i_plane_index;
    logic signed [31:0] i_ax, i_ay, i_az, i_aw, i_bx, i_by, i_bz;
    logic o_valid, o_visible;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    frustum_visibility_cull u_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .i_plane_set, .i_plane_index,
        .i_ax, .i_ay, .i_az, .i_aw, .i_bx, .i_by, .i_bz, .o_valid, .o_visible,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    fvc_pkg::t_plane base_tbl [fvc_pkg::NUM_FIXED];
    fvc_pkg::t_plane excl_tbl [fvc_pkg::NUM_FIXED];
    fvc_pkg::t_plane incl_tbl [16];
    logic [4:0] inc_count;
    logic       excl_on;

    bit    vis_q [$];
    int    n_err, n_seen, n_tests, n_writes, cycles;
    t_stim dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("tb: timeout");
            $display("tb: errors");
            $finish;
        end
    end

    task automatic report(string what, bit exp, bit got);
        $display("mismatch %s: expected %0d got %0d at cycle %0d", what, exp, got, cycles);
        n_err++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_seen++;
            if (vis_q.size() == 0) report("unexpected transaction", 1'b0, o_visible);
            else begin
                bit e;
                e = vis_q.pop_front();
                if (e !== o_visible) report("visible", e, o_visible);
            end
        end
    end

    function automatic logic signed [127:0] margin(fvc_pkg::t_plane p, logic [1:0] cmd,
            logic signed [31:0] u [3], logic signed [31:0] v [3],
            logic signed [31:0] w, bit inner);
        logic signed [127:0] acc, n, a, ab, cu, cv, r;
        logic signed [31:0] pc [3];
        pc = '{p.a, p.b, p.c};
        acc = $signed(p.d);
        acc = acc * 65536;
        if (cmd == fvc_pkg::CMD_BOX_MM) acc = acc * 2;
        n = 0;
        if (cmd == fvc_pkg::CMD_SPHERE) begin
            r = w;
            r = r * 65536;
            acc = inner ? acc - r : acc + r;
        end
        for (int i = 0; i < 3; i++) begin
            a = pc[i];
            ab = (a < 0) ? -a : a;
            cu = u[i];
            cv = v[i];
            if (cmd == fvc_pkg::CMD_SPHERE) acc = acc + a * cu;
            else if (cmd == fvc_pkg::CMD_BOX_MM) begin
                acc = acc + a * (cu + cv);
                n = n + ab * (cv - cu);
            end else begin
                acc = acc + a * cu;
                n = n + ab * cv;
            end
        end
        return inner ? acc - n : acc + n;
    endfunction

    function automatic bit visibility(t_stim s);
        logic signed [31:0] u [3], v [3];
        logic signed [127:0] m;
        int ninc;
        bit vis, enclosed;
        for (int i = 0; i < 3; i++) begin
            u[i] = s.f[i];
            v[i] = s.f[4+i];
        end
        ninc = (inc_count > 16) ? 16 : inc_count;
        vis = 1'b1;
        for (int i = 0; i < fvc_pkg::NUM_FIXED; i++)
            if (margin(base_tbl[i], s.cmd, u, v, s.f[3], 1'b0) < 0) vis = 1'b0;
        for (int i = 0; i < ninc; i++)
            if (margin(incl_tbl[i], s.cmd, u, v, s.f[3], 1'b0) < 0) vis = 1'b0;
        if (vis && excl_on) begin
            enclosed = 1'b1;
            for (int i = 0; i < fvc_pkg::NUM_FIXED; i++) begin
                m = margin(excl_tbl[i], s.cmd, u, v, s.f[3], 1'b1);
                if (s.cmd == fvc_pkg::CMD_SPHERE ? !(m > 0) : (m < 0)) enclosed = 1'b0;
            end
            if (enclosed) vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic void store_plane(t_stim s);
        fvc_pkg::t_plane p;
        p = {s.f[3], s.f[2], s.f[1], s.f[0]};
        if (s.set == fvc_pkg::SET_BASE && s.idx < fvc_pkg::NUM_FIXED) base_tbl[s.idx] = p;
        else if (s.set == fvc_pkg::SET_EXCL && s.idx < fvc_pkg::NUM_FIXED) excl_tbl[s.idx] = p;
        else if (s.set == fvc_pkg::SET_INCL) incl_tbl[s.idx] = p;
    endfunction

    // called at a falling edge; leaves start high
    task automatic issue(t_stim s);
        i_cmd = s.cmd;
        i_plane_set = s.set;
        i_plane_index = s.idx;
        {i_bz, i_by, i_bx, i_aw, i_az, i_ay, i_ax} = s.f;
        start = 1'b1;
        while (busy) @(negedge i_clk);
        if (s.cmd == fvc_pkg::CMD_WRITE) begin
            store_plane(s);
            n_writes++;
        end else begin
            vis_q.push_back(s.typed ? s.vis : visibility(s));
            n_tests++;
        end
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int g, r;
        r = $urandom_range(0, 99);
        g = (r < 60) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (g > 0) begin
            start = 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(logic regsel, logic [31:0] val);
        start = 1'b0;
        while (vis_q.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {regsel, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (regsel == fvc_pkg::REG_INC_COUNT) inc_count = val[4:0];
        else excl_on = val[0];
    endtask

    function automatic t_stim mk(logic [1:0] cmd, logic [1:0] set, logic [3:0] idx,
            logic [6:0][31:0] f, bit typed, bit vis);
        t_stim s;
        s.cmd = cmd; s.set = set; s.idx = idx; s.f = f; s.typed = typed; s.vis = vis;
        return s;
    endfunction

    function automatic logic [31:0] coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
    endfunction

    function automatic logic [31:0] normal();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 32'h0;
        if (r < 5) return 32'h0001_0000;
        if (r < 7) return 32'hffff_0000;
        if (r < 9) return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
        return $urandom;
    endfunction

    function automatic t_stim rand_item();
        t_stim s;
        logic [6:0][31:0] f;
        int r;
        r = $urandom_range(0, 99);
        for (int i = 0; i < 7; i++) f[i] = coord();
        if (r < 35) begin
            f[0] = normal(); f[1] = normal(); f[2] = normal();
            s = mk(fvc_pkg::CMD_WRITE,
                   ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                   4'($urandom_range(0, 15)), f, 1'b0, 1'b0);
            if (s.set != fvc_pkg::SET_INCL && $urandom_range(0, 3) != 0)
                s.idx = 4'($urandom_range(0, 5));
        end else begin
            s = mk(2'($urandom_range(1, 3)), 2'($urandom), 4'($urandom), f, 1'b0, 1'b0);
        end
        return s;
    endfunction

    localparam logic [31:0] QMAX = 32'h7fff_ffff;
    localparam logic [31:0] QMIN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MONE = 32'hffff_0000;

    initial begin
        logic [4:0]  phase_count [6];
        logic        phase_excl  [6];
        phase_count = '{5'd16, 5'd31, 5'd3, 5'd1, 5'd20, 5'd0};
        phase_excl  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        n_err = 0; n_seen = 0; n_tests = 0; n_writes = 0;
        start = 1'b0; i_cmd = '0; i_plane_set = '0; i_plane_index = '0;
        {i_ax, i_ay, i_az, i_aw, i_bx, i_by, i_bz} = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int i = 0; i < fvc_pkg::NUM_FIXED; i++) begin
            base_tbl[i] = '0;
            excl_tbl[i] = '0;
        end
        for (int i = 0; i < 16; i++) incl_tbl[i] = '0;
        inc_count = '0;
        excl_on = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        dir_rows.push_back(mk(fvc_pkg::CMD_SPHERE, 2'd0, 4'd0, '0, 1'b1, 1'b1));
        dir_rows.push_back(mk(fvc_pkg::CMD_SPHERE, 2'd0, 4'd0,
                              {96'h0, MONE, QMAX, QMIN, QMAX}, 1'b1, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_BOX_CE, 2'd0, 4'd0,
                              {QMIN, QMIN, QMIN, 32'h0, QMAX, QMIN, QMAX}, 1'b1, 1'b1));
        dir_rows.push_back(mk(fvc_pkg::CMD_BOX_MM, 2'd0, 4'd0,
                              {QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX}, 1'b1, 1'b1));
        // ignored writes: bad table and index past the end
        dir_rows.push_back(mk(fvc_pkg::CMD_WRITE, 2'd3, 4'd0, {96'h0, MONE, 96'h0},
                              1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_WRITE, fvc_pkg::SET_BASE, 4'd7,
                              {96'h0, MONE, 96'h0}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_WRITE, fvc_pkg::SET_EXCL, 4'd15,
                              {96'h0, MONE, 96'h0}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_SPHERE, 2'd0, 4'd0, '0, 1'b1, 1'b1));
        dir_rows.push_back(mk(fvc_pkg::CMD_WRITE, fvc_pkg::SET_BASE, 4'd0,
                              {96'h0, 32'h0, 64'h0, ONE}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_WRITE, fvc_pkg::SET_BASE, 4'd5,
                              {96'h0, QMIN, QMAX, QMIN, QMAX}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_WRITE, fvc_pkg::SET_INCL, 4'd15,
                              {96'h0, QMAX, QMIN, QMAX, QMIN}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_WRITE, fvc_pkg::SET_EXCL, 4'd0,
                              {96'h0, ONE, 64'h0, ONE}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_WRITE, fvc_pkg::SET_EXCL, 4'd5,
                              {96'h0, ONE, 32'h0, MONE, 32'h0}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_SPHERE, 2'd0, 4'd0,
                              {96'h0, ONE, 64'h0, 32'hfffe_0000}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_SPHERE, 2'd0, 4'd0,
                              {96'h0, QMIN, QMAX, QMAX, QMAX}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_SPHERE, 2'd0, 4'd0,
                              {96'h0, QMAX, QMIN, QMIN, QMIN}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_BOX_CE, 2'd0, 4'd0,
                              {MONE, MONE, MONE, 32'h0, 64'h0, QMIN}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_BOX_CE, 2'd0, 4'd0,
                              {QMAX, QMAX, QMAX, QMIN, QMAX, QMAX, QMAX}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_BOX_MM, 2'd0, 4'd0,
                              {QMIN, QMIN, QMIN, 32'h0, QMAX, QMAX, QMAX}, 1'b0, 1'b0));
        dir_rows.push_back(mk(fvc_pkg::CMD_BOX_MM, 2'd0, 4'd0,
                              {64'h0, ONE, 32'h0, 64'h0, 32'hfffd_0000}, 1'b0, 1'b0));

        foreach (dir_rows[k]) begin
            issue(dir_rows[k]);
            idle_gap();
        end

        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(fvc_pkg::REG_INC_COUNT, {27'h0, phase_count[ph]});
            cfg_write(fvc_pkg::REG_EXCL_EN, {31'h0, phase_excl[ph]});
            repeat (90) begin
                issue(rand_item());
                idle_gap();
            end
        end
        start = 1'b0;

        while (vis_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("tb: %0d plane writes, %0d visibility tests, %0d results checked",
                 n_writes, n_tests, n_seen);
        $display("tb: six register settings incl. count 0, 16 and above, exclusion on/off");
        if (n_err == 0 && vis_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
design/fvc_pkg.sv
design/fvc_ram.sv
design/frustum_visibility_cull.sv
design/fvc_checker.sv
dv/tb.sv
